/* rtl/core/i2c_bcd_register_access_core_defines.svh */
`ifndef I2C_BCD_REGISTER_ACCESS_CORE_DEFINES_SVH
`define I2C_BCD_REGISTER_ACCESS_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define I2CBRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define I2CBRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/i2cbra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2cbra_pkg;

  localparam int unsigned AddrW = 7;
  localparam int unsigned HalfW = 16;
  localparam int unsigned CfgW  = 16;

  typedef enum logic [0:0] {
    CFG_DEVICE_ADDRESS = 1'b0,
    CFG_HALF_PERIOD    = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_DONE_OK   = 5'd1,
    PH_DONE_FAIL = 5'd2,
    PH_ST_REL    = 5'd3,
    PH_ST_PULL   = 5'd4,
    PH_RS_LOW    = 5'd5,
    PH_RS_REL    = 5'd6,
    PH_RS_PULL   = 5'd7,
    PH_ADW_LO    = 5'd8,
    PH_ADW_HI    = 5'd9,
    PH_IDX_LO    = 5'd10,
    PH_IDX_HI    = 5'd11,
    PH_DAT_LO    = 5'd12,
    PH_DAT_HI    = 5'd13,
    PH_ADR_LO    = 5'd14,
    PH_ADR_HI    = 5'd15,
    PH_RX_LO     = 5'd16,
    PH_RX_HI     = 5'd17,
    PH_SP_LO     = 5'd18,
    PH_SP_HI     = 5'd19,
    PH_SP_REL    = 5'd20,
    PH_FSP_LO    = 5'd21,
    PH_FSP_HI    = 5'd22,
    PH_FSP_REL   = 5'd23
  } phase_e;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       failed;
    logic [6:0] read_value;
  } res_t;

  // Binary to two BCD digits, hundreds dropped.
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [7:0]  r8;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    if (v >= 8'd200) begin
      r8 = v - 8'd200;
    end else if (v >= 8'd100) begin
      r8 = v - 8'd100;
    end else begin
      r8 = v;
    end
    r        = r8[6:0];
    prod     = 15'(r) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    ones     = r - tens_x10;
    return {tens, ones[3:0]};
  endfunction

  // Bits 6..0 as BCD: 40/20/10 weights plus the low nibble.
  function automatic logic [6:0] from_bcd(input logic [7:0] b);
    logic [6:0] v;
    v = {3'd0, b[3:0]};
    if (b[6]) v = v + 7'd40;
    if (b[5]) v = v + 7'd20;
    if (b[4]) v = v + 7'd10;
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/i2cbra_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2cbra_seq (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic                     request_i,
  input  wire logic                     command_i,
  input  wire logic [7:0]               reg_index_i,
  input  wire logic [7:0]               write_value_i,
  input  wire logic                     sda_sample_i,
  input  wire logic [i2cbra_pkg::AddrW-1:0] device_address_i,
  input  wire logic [i2cbra_pkg::HalfW-1:0] half_period_i,
  output i2cbra_pkg::res_t              res_o
);

  import i2cbra_pkg::*;

  phase_e           phase_q, phase_d;
  logic [3:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic [HalfW-1:0] tick_q, tick_d;
  logic             cmd_q, cmd_d;
  logic [7:0]       index_q, index_d;
  logic [7:0]       value_q, value_d;
  logic [6:0]       rx_q, rx_d;

  logic [HalfW-1:0] hp;
  logic             idle_like;
  logic             is_tx;

  assign hp        = (half_period_i == '0) ? HalfW'(1) : half_period_i;
  assign idle_like = (phase_q <= PH_DONE_FAIL) || (phase_q > PH_FSP_REL);

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    tick_d  = tick_q;
    cmd_d   = cmd_q;
    index_d = index_q;
    value_d = value_q;
    rx_d    = rx_q;
    if (step_i) begin
      if (idle_like) begin
        if (request_i) begin
          cmd_d   = command_i;
          index_d = reg_index_i;
          value_d = write_value_i;
          rx_d    = '0;
          bit_d   = '0;
          shift_d = '0;
          tick_d  = '0;
          phase_d = PH_ST_REL;
        end else begin
          phase_d = PH_IDLE;
        end
      end else if (({1'b0, tick_q} + 17'd1) >= {1'b0, hp}) begin
        tick_d = '0;
        unique case (phase_q)
          PH_ST_REL: phase_d = PH_ST_PULL;
          PH_ST_PULL: begin
            phase_d = PH_ADW_LO;
            bit_d   = '0;
            shift_d = {device_address_i, 1'b0};
          end
          PH_RS_LOW: phase_d = PH_RS_REL;
          PH_RS_REL: phase_d = PH_RS_PULL;
          PH_RS_PULL: begin
            phase_d = PH_ADR_LO;
            bit_d   = '0;
            shift_d = {device_address_i, 1'b1};
          end
          PH_ADW_LO: phase_d = PH_ADW_HI;
          PH_IDX_LO: phase_d = PH_IDX_HI;
          PH_DAT_LO: phase_d = PH_DAT_HI;
          PH_ADR_LO: phase_d = PH_ADR_HI;
          PH_ADW_HI, PH_IDX_HI, PH_DAT_HI, PH_ADR_HI: begin
            if (!bit_q[3]) begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 4'd1;
              phase_d = phase_e'(phase_q - 5'd1);
            end else if (sda_sample_i) begin
              rx_d    = '0;
              phase_d = PH_FSP_LO;
            end else if (phase_q == PH_ADW_HI) begin
              phase_d = PH_IDX_LO;
              bit_d   = '0;
              shift_d = index_q;
            end else if (phase_q == PH_IDX_HI) begin
              if (cmd_q) begin
                phase_d = PH_DAT_LO;
                bit_d   = '0;
                shift_d = to_bcd(value_q);
              end else begin
                phase_d = PH_RS_LOW;
              end
            end else if (phase_q == PH_DAT_HI) begin
              phase_d = PH_SP_LO;
            end else begin
              bit_d   = '0;
              shift_d = '0;
              phase_d = PH_RX_LO;
            end
          end
          PH_RX_LO: phase_d = PH_RX_HI;
          PH_RX_HI: begin
            if (!bit_q[3]) begin
              shift_d = {shift_q[6:0], sda_sample_i};
              bit_d   = bit_q + 4'd1;
              phase_d = PH_RX_LO;
            end else begin
              rx_d    = from_bcd(shift_q);
              phase_d = PH_SP_LO;
            end
          end
          PH_SP_LO:   phase_d = PH_SP_HI;
          PH_SP_HI:   phase_d = PH_SP_REL;
          PH_SP_REL:  phase_d = PH_DONE_OK;
          PH_FSP_LO:  phase_d = PH_FSP_HI;
          PH_FSP_HI:  phase_d = PH_FSP_REL;
          PH_FSP_REL: phase_d = PH_DONE_FAIL;
          default:    phase_d = PH_IDLE;
        endcase
      end else begin
        tick_d = tick_q + HalfW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      shift_q <= '0;
      tick_q  <= '0;
      cmd_q   <= 1'b0;
      index_q <= '0;
      value_q <= '0;
      rx_q    <= '0;
    end else begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      tick_q  <= tick_d;
      cmd_q   <= cmd_d;
      index_q <= index_d;
      value_q <= value_d;
      rx_q    <= rx_d;
    end
  end

  // Line levels and status follow the updated state.
  assign is_tx = (phase_d >= PH_ADW_LO) && (phase_d <= PH_ADR_HI);

  always_comb begin
    res_o.scl_level = !((phase_d == PH_RS_LOW) || (phase_d == PH_RX_LO) ||
                        (phase_d == PH_SP_LO) || (phase_d == PH_FSP_LO) ||
                        (is_tx && !phase_d[0]));
    res_o.sda_pull_low = (phase_d == PH_ST_PULL) || (phase_d == PH_RS_PULL) ||
                         (phase_d == PH_SP_LO) || (phase_d == PH_SP_HI) ||
                         (phase_d == PH_FSP_LO) || (phase_d == PH_FSP_HI) ||
                         (is_tx && !bit_d[3] && !shift_d[7]);
    res_o.busy_res   = (phase_d > PH_DONE_FAIL) && (phase_d <= PH_FSP_REL);
    res_o.done_res   = (phase_d == PH_DONE_OK) || (phase_d == PH_DONE_FAIL);
    res_o.failed     = (phase_d == PH_DONE_FAIL);
    res_o.read_value = ((phase_d == PH_DONE_OK) && !cmd_d) ? rx_d : 7'd0;
  end

endmodule

`default_nettype wire

/* rtl/core/i2c_bcd_register_access_core.sv */
// Channel  Handshake               Payload
// in       in_valid_i/in_ready_o   request, command, reg_index, write_value, sda_sample
// out      out_valid_o/out_ready_i scl_level, sda_pull_low, busy_res, done_res,
//                                  failed, read_value
// cfg      cfg_we_i                cfg_index_i, cfg_data_i
//
// One request per cycle while in_ready_o is high; its result is registered into the output register.
// The bus sequencer moves at most one step per request, paced by half_period.
// Reset clears the sequencer to idle with the bus released; config to 50 / 250.
// A held result stalls input only while out_ready_i is low.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_bcd_register_access_core_defines.svh"

module i2c_bcd_register_access_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         request_i,
  input  wire logic                         command_i,
  input  wire logic [7:0]                   reg_index_i,
  input  wire logic [7:0]                   write_value_i,
  input  wire logic                         sda_sample_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         scl_level_o,
  output      logic                         sda_pull_low_o,
  output      logic                         busy_res_o,
  output      logic                         done_res_o,
  output      logic                         failed_o,
  output      logic [6:0]                   read_value_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [0:0]                   cfg_index_i,
  input  wire logic [i2cbra_pkg::CfgW-1:0]  cfg_data_i
);

  import i2cbra_pkg::*;

  logic [AddrW-1:0] dev_addr_q;
  logic [HalfW-1:0] half_q;
  logic             out_valid_q;
  res_t             res_d, res_q;
  logic             accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= AddrW'(50);
      half_q     <= HalfW'(250);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data_i[AddrW-1:0];
        CFG_HALF_PERIOD:    half_q     <= cfg_data_i[HalfW-1:0];
      endcase
    end
  end

  i2cbra_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .request_i        (request_i),
    .command_i        (command_i),
    .reg_index_i      (reg_index_i),
    .write_value_i    (write_value_i),
    .sda_sample_i     (sda_sample_i),
    .device_address_i (dev_addr_q),
    .half_period_i    (half_q),
    .res_o            (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = res_q.scl_level;
  assign sda_pull_low_o = res_q.sda_pull_low;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign failed_o       = res_q.failed;
  assign read_value_o   = res_q.read_value;

  `I2CBRA_ASSERT(a_stall_blocks_in, out_valid_o && !out_ready_i |-> !in_ready_o, "input taken while result stalled")
  `I2CBRA_ASSERT(a_fail_with_done, out_valid_o && failed_o |-> done_res_o, "failed without done")
  `I2CBRA_ASSERT(a_done_not_busy, out_valid_o && done_res_o |-> !busy_res_o, "done while busy")
  `I2CBRA_ASSERT(a_value_on_ok, out_valid_o && (read_value_o != 7'd0) |-> done_res_o && !failed_o, "value outside successful read")

endmodule

`default_nettype wire

/* sim/i2c_bcd_register_access_core_tb.sv */
`timescale 1ns / 1ps

module i2c_bcd_register_access_core_tb;
  import i2cbra_pkg::*;

  localparam logic CMD_READ    = 1'b0;
  localparam logic CMD_WRITE   = 1'b1;
  localparam int   STALL_LIMIT = 2000;
  localparam int   REPORT_MAX  = 200;

  typedef enum logic [2:0] {
    ACK_ALL,
    NACK_ADDR_W,
    NACK_INDEX,
    NACK_DATA,
    NACK_ADDR_R
  } nack_pos_e;

  typedef struct packed {
    logic       req;
    logic       cmd;
    logic [7:0] idx;
    logic [7:0] val;
    logic       sda;
  } tick_t;

  typedef struct packed {
    phase_e      ph;
    logic [3:0]  bits;
    logic [7:0]  sh;
    logic [15:0] div;
    logic        cmd;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [6:0]  rx;
  } bus_state_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             drv_valid = 1'b0;
  tick_t            drv = '0;
  logic             out_ready = 1'b0;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       scl_level_o;
  logic       sda_pull_low_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       failed_o;
  logic [6:0] read_value_o;

  tick_t tick_q[$];
  res_t  want_q[$];

  // bus state as the predictor sees it, and the copy used to plan SDA answers
  bus_state_t  pred_st = '0;
  logic [6:0]  pred_adr = 7'd50;
  logic [15:0] pred_hp = 16'd250;
  bus_state_t  plan_st = '0;
  logic [6:0]  plan_adr = 7'd50;
  logic [15:0] plan_hp = 16'd250;
  nack_pos_e   xfer_nack = ACK_ALL;
  logic [7:0]  xfer_rx = '0;
  int          planned = 0;

  int drv_pct = 0;
  int mon_pct = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  res_t want_res;
  res_t got_res;

  i2c_bcd_register_access_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (drv_valid),
    .in_ready_o     (in_ready_o),
    .request_i      (drv.req),
    .command_i      (drv.cmd),
    .reg_index_i    (drv.idx),
    .write_value_i  (drv.val),
    .sda_sample_i   (drv.sda),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .scl_level_o    (scl_level_o),
    .sda_pull_low_o (sda_pull_low_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .failed_o       (failed_o),
    .read_value_o   (read_value_o),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] bcd_of(input logic [7:0] v);
    int unsigned r;
    r = int'(v) % 100;
    return {4'(r / 10), 4'(r % 10)};
  endfunction

  function automatic logic [6:0] bcd_value(input logic [7:0] b);
    return 7'(b[3:0]) + (b[6] ? 7'd40 : 7'd0) + (b[5] ? 7'd20 : 7'd0) +
           (b[4] ? 7'd10 : 7'd0);
  endfunction

  function automatic logic in_xfer(input bus_state_t s);
    return s.ph > PH_DONE_FAIL && s.ph <= PH_FSP_REL;
  endfunction

  function automatic void load_byte(inout bus_state_t s, input phase_e p,
                                    input logic [7:0] b);
    s.ph   = p;
    s.bits = '0;
    s.sh   = b;
  endfunction

  function automatic void bus_advance(inout bus_state_t s, input logic [6:0] adr,
                                      input logic sda);
    case (s.ph)
      PH_ST_REL:  s.ph = PH_ST_PULL;
      PH_ST_PULL: load_byte(s, PH_ADW_LO, {adr, 1'b0});
      PH_RS_LOW:  s.ph = PH_RS_REL;
      PH_RS_REL:  s.ph = PH_RS_PULL;
      PH_RS_PULL: load_byte(s, PH_ADR_LO, {adr, 1'b1});
      PH_ADW_LO, PH_IDX_LO, PH_DAT_LO, PH_ADR_LO: s.ph = phase_e'(s.ph + 5'd1);
      PH_ADW_HI, PH_IDX_HI, PH_DAT_HI, PH_ADR_HI: begin
        if (s.bits < 4'd8) begin
          s.sh   = {s.sh[6:0], 1'b0};
          s.bits = s.bits + 4'd1;
          s.ph   = phase_e'(s.ph - 5'd1);
        end else if (sda) begin
          s.rx = '0;
          s.ph = PH_FSP_LO;
        end else if (s.ph == PH_ADW_HI) begin
          load_byte(s, PH_IDX_LO, s.idx);
        end else if (s.ph == PH_IDX_HI) begin
          if (s.cmd == CMD_WRITE) begin
            load_byte(s, PH_DAT_LO, bcd_of(s.val));
          end else begin
            s.ph = PH_RS_LOW;
          end
        end else if (s.ph == PH_DAT_HI) begin
          s.ph = PH_SP_LO;
        end else begin
          s.bits = '0;
          s.sh   = '0;
          s.ph   = PH_RX_LO;
        end
      end
      PH_RX_LO: s.ph = PH_RX_HI;
      PH_RX_HI: begin
        if (s.bits < 4'd8) begin
          s.sh   = {s.sh[6:0], sda};
          s.bits = s.bits + 4'd1;
          s.ph   = PH_RX_LO;
        end else begin
          s.rx = bcd_value(s.sh);
          s.ph = PH_SP_LO;
        end
      end
      PH_SP_LO:   s.ph = PH_SP_HI;
      PH_SP_HI:   s.ph = PH_SP_REL;
      PH_SP_REL:  s.ph = PH_DONE_OK;
      PH_FSP_LO:  s.ph = PH_FSP_HI;
      PH_FSP_HI:  s.ph = PH_FSP_REL;
      PH_FSP_REL: s.ph = PH_DONE_FAIL;
      default:    s.ph = PH_IDLE;
    endcase
  endfunction

  // one tick of the sequencer; returns the bus and status levels after it
  function automatic res_t bus_tick(inout bus_state_t s, input logic [6:0] adr,
                                    input logic [15:0] hp, input tick_t t);
    res_t       r;
    logic       tx;
    logic [4:0] code;
    if (!in_xfer(s)) begin
      if (t.req) begin
        s.cmd  = t.cmd;
        s.idx  = t.idx;
        s.val  = t.val;
        s.rx   = '0;
        s.bits = '0;
        s.sh   = '0;
        s.div  = '0;
        s.ph   = PH_ST_REL;
      end else begin
        s.ph = PH_IDLE;
      end
    end else if (32'(s.div) + 1 >= ((hp == '0) ? 32'd1 : 32'(hp))) begin
      s.div = '0;
      bus_advance(s, adr, t.sda);
    end else begin
      s.div = s.div + 16'd1;
    end
    code = s.ph;
    tx = s.ph >= PH_ADW_LO && s.ph <= PH_ADR_HI;
    r.scl_level = !(s.ph == PH_RS_LOW || s.ph == PH_RX_LO || s.ph == PH_SP_LO ||
                    s.ph == PH_FSP_LO || (tx && !code[0]));
    r.sda_pull_low = s.ph == PH_ST_PULL || s.ph == PH_RS_PULL || s.ph == PH_SP_LO ||
                     s.ph == PH_SP_HI || s.ph == PH_FSP_LO || s.ph == PH_FSP_HI ||
                     (tx && s.bits < 4'd8 && !s.sh[7]);
    r.busy_res   = in_xfer(s);
    r.done_res   = s.ph == PH_DONE_OK || s.ph == PH_DONE_FAIL;
    r.failed     = s.ph == PH_DONE_FAIL;
    r.read_value = (s.ph == PH_DONE_OK && s.cmd == CMD_READ) ? s.rx : '0;
    return r;
  endfunction

  // SDA as the device would drive it on this tick: ACK/NACK and read bits
  function automatic logic device_sda(input bus_state_t s);
    logic [15:0] hpe;
    nack_pos_e   at;
    hpe = (plan_hp == '0) ? 16'd1 : plan_hp;
    if (!in_xfer(s) || 32'(s.div) + 1 < 32'(hpe)) return 1'($urandom_range(0, 1));
    case (s.ph)
      PH_ADW_HI: at = NACK_ADDR_W;
      PH_IDX_HI: at = NACK_INDEX;
      PH_DAT_HI: at = NACK_DATA;
      PH_ADR_HI: at = NACK_ADDR_R;
      PH_RX_HI: begin
        if (s.bits < 4'd8) return xfer_rx[3'(7 - s.bits)];
        return 1'($urandom_range(0, 1));
      end
      default: return 1'($urandom_range(0, 1));
    endcase
    if (s.bits < 4'd8) return 1'($urandom_range(0, 1));
    return at == xfer_nack;
  endfunction

  task automatic plan_tick(input logic req, input logic cmd, input logic [7:0] idx,
                           input logic [7:0] val);
    tick_t t;
    t.req = req;
    t.cmd = cmd;
    t.idx = idx;
    t.val = val;
    t.sda = device_sda(plan_st);
    void'(bus_tick(plan_st, plan_adr, plan_hp, t));
    tick_q.push_back(t);
    planned++;
  endtask

  // finish any transfer still running, request a new one, run it to its end
  task automatic plan_xfer(input logic cmd, input logic [7:0] idx, input logic [7:0] val,
                           input nack_pos_e nk, input logic [7:0] rx, input int limit,
                           input int gap);
    int n;
    n = 0;
    xfer_nack = nk;
    xfer_rx = rx;
    while (in_xfer(plan_st) && n < limit) begin
      plan_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
                8'($urandom));
      n++;
    end
    if (n < limit) begin
      plan_tick(1'b1, cmd, idx, val);
      n++;
    end
    while (plan_st.ph != PH_DONE_OK && plan_st.ph != PH_DONE_FAIL && n < limit) begin
      plan_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
                8'($urandom));
      n++;
    end
    repeat (gap) plan_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
  endtask

  task automatic rand_xfer(input int gap_max);
    nack_pos_e nk;
    nk = ACK_ALL;
    if ($urandom_range(0, 5) == 0) nk = nack_pos_e'($urandom_range(1, 4));
    plan_xfer(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), nk, 8'($urandom),
              100000, $urandom_range(0, gap_max));
  endtask

  task automatic write_reg(input cfg_idx_e which, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (which == CFG_DEVICE_ADDRESS) plan_adr = data[6:0];
    else plan_hp = data;
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || want_q.size() != 0 || drv_valid) @(posedge clk_i);
  endtask

  task automatic check_field(input string what, input logic [6:0] want_v,
                             input logic [6:0] got_v);
    if (want_v !== got_v) begin
      if (mismatches < REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      send_gap  <= 0;
      pred_st   <= '0;
      pred_adr  <= 7'd50;
      pred_hp   <= 16'd250;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEVICE_ADDRESS) pred_adr <= cfg_data[6:0];
        else pred_hp <= cfg_data;
      end
      if (drv_valid && in_ready_o) want_q.push_back(bus_tick(pred_st, pred_adr, pred_hp, drv));
      if (!drv_valid || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          drv_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          drv       <= tick_q.pop_front();
          drv_valid <= 1'b1;
          if ($urandom_range(0, 99) < drv_pct) send_gap <= $urandom_range(1, 10);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        got_res = {scl_level_o, sda_pull_low_o, busy_res_o, done_res_o, failed_o,
                   read_value_o};
        if (want_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: unexpected result, expected none, got %h", $time, got_res);
          mismatches++;
        end else begin
          want_res = want_q.pop_front();
          check_field("scl_level", 7'(want_res.scl_level), 7'(got_res.scl_level));
          check_field("sda_pull_low", 7'(want_res.sda_pull_low), 7'(got_res.sda_pull_low));
          check_field("busy_res", 7'(want_res.busy_res), 7'(got_res.busy_res));
          check_field("done_res", 7'(want_res.done_res), 7'(got_res.done_res));
          check_field("failed", 7'(want_res.failed), 7'(got_res.failed));
          check_field("read_value", want_res.read_value, got_res.read_value);
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < mon_pct) begin
        recv_stall <= $urandom_range(0, 9);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (drv_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: slow divider, transfer left running
    drv_pct = 20;
    mon_pct = 20;
    plan_xfer(CMD_READ, 8'h00, 8'h00, ACK_ALL, 8'hFF, 252, 0);

    // running read finishes with the widest decoded value, then hundreds dropped
    drain();
    write_reg(CFG_DEVICE_ADDRESS, 16'd0);
    write_reg(CFG_HALF_PERIOD, 16'd1);
    plan_xfer(CMD_WRITE, 8'h7F, 8'd199, ACK_ALL, 8'hFF, 100000, 2);

    // zero half period runs as one tick per half
    drain();
    drv_pct = 0;
    mon_pct = 40;
    write_reg(CFG_DEVICE_ADDRESS, 16'd127);
    write_reg(CFG_HALF_PERIOD, 16'd0);
    plan_xfer(CMD_WRITE, 8'h11, 8'd42, NACK_ADDR_W, 8'h00, 100000, 0);
    plan_xfer(CMD_READ, 8'h22, 8'd0, NACK_INDEX, 8'h00, 100000, 0);
    plan_xfer(CMD_WRITE, 8'h33, 8'd77, NACK_DATA, 8'h00, 100000, 2);
    plan_xfer(CMD_READ, 8'h44, 8'd0, NACK_ADDR_R, 8'h00, 100000, 0);

    // widest divider, settings changed again mid-transfer
    drain();
    drv_pct = 30;
    mon_pct = 0;
    write_reg(CFG_DEVICE_ADDRESS, 16'd85);
    write_reg(CFG_HALF_PERIOD, 16'hFFFF);
    plan_xfer(CMD_WRITE, 8'h0F, 8'd123, ACK_ALL, 8'h00, 20, 0);
    drain();
    write_reg(CFG_HALF_PERIOD, 16'd1);
    write_reg(CFG_DEVICE_ADDRESS, 16'd42);
    plan_xfer(CMD_READ, 8'hF0, 8'd0, ACK_ALL, 8'h87, 100000, 0);

    // closing stretch without idling
    drain();
    drv_pct = 0;
    mon_pct = 0;
    write_reg(CFG_DEVICE_ADDRESS, 16'($urandom_range(0, 127)));
    write_reg(CFG_HALF_PERIOD, 16'd2);
    rand_xfer(0);

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/i2cbra_pkg.sv
rtl/core/i2cbra_seq.sv
rtl/core/i2c_bcd_register_access_core.sv
sim/i2c_bcd_register_access_core_tb.sv
